// File: src/tdmdc_pkg.sv
`timescale 1ns / 1ps

package tdmdc_pkg;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DOWN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_PERIOD_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_PERIOD_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ENABLE    = 3'd5;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic [1:0] CATH_DARK  = 2'b00;
  localparam logic [1:0] CATH_TENS  = 2'b01;
  localparam logic [1:0] CATH_UNITS = 2'b10;

  localparam logic [7:0] DEC_RECIP       = 8'd205;
  localparam int unsigned DEC_RECIP_SHIFT = 11;

  typedef struct packed {
    logic       func;
    logic [7:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] segments;
    logic       tens_lit;
    logic       units_lit;
    logic [7:0] shown_number;
    logic       status;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_count;
    logic do_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [6:0] glyph(input logic [7:0] d);
    logic [6:0] g;
    begin
      g = 7'h00;
      if (d[7:4] == 4'h0) begin
        case (d[3:0])
          4'h0: g = 7'h3F;
          4'h1: g = 7'h06;
          4'h2: g = 7'h5B;
          4'h3: g = 7'h4F;
          4'h4: g = 7'h66;
          4'h5: g = 7'h6D;
          4'h6: g = 7'h7D;
          4'h7: g = 7'h07;
          4'h8: g = 7'h7F;
          4'h9: g = 7'h6F;
          4'hA: g = 7'h77;
          4'hB: g = 7'h7C;
          4'hC: g = 7'h39;
          4'hD: g = 7'h5E;
          4'hE: g = 7'h79;
          default: g = 7'h71;
        endcase
      end
      return g;
    end
  endfunction

endpackage

// File: src/tdmdc_ctrl.sv
`timescale 1ns / 1ps

module tdmdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdmdc_pkg::dp_sts_t  sts,
  output tdmdc_pkg::dp_cmd_t  cmd
);

  tdmdc_pkg::state_t state_r;
  tdmdc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdmdc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdmdc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tdmdc_pkg::S_COUNT;
      end
      tdmdc_pkg::S_COUNT: begin
        state_nxt = tdmdc_pkg::S_DIGIT;
      end
      tdmdc_pkg::S_DIGIT: begin
        if (sts.out_free) state_nxt = tdmdc_pkg::S_IDLE;
      end
      default: state_nxt = tdmdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.capture  = 1'b0;
    cmd.do_count = 1'b0;
    cmd.do_digit = 1'b0;
    unique case (state_r)
      tdmdc_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      tdmdc_pkg::S_COUNT: begin
        cmd.do_count = 1'b1;
      end
      tdmdc_pkg::S_DIGIT: begin
        cmd.do_digit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: src/tdmdc_dp.sv
`timescale 1ns / 1ps

module tdmdc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tdmdc_pkg::in_word_t                   in_word,
  input  tdmdc_pkg::dp_cmd_t                    cmd,
  output tdmdc_pkg::dp_sts_t                    sts,
  input  logic                                  cfg_wr,
  input  logic [tdmdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                           cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tdmdc_pkg::out_word_t                  out_word
);

  tdmdc_pkg::in_word_t  in_word_r;
  tdmdc_pkg::out_word_t out_word_r, out_word_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [1:0]  radix_r, radix_nxt;
  logic        count_down_r, count_down_nxt;
  logic [15:0] count_period_r, count_period_nxt;
  logic [7:0]  digit_period_r, digit_period_nxt;
  logic        out_en_r, out_en_nxt;
  logic        cnt_en_r, cnt_en_nxt;

  logic [7:0]  held_r, held_nxt;
  logic        lit_units_r, lit_units_nxt;
  logic [15:0] cpre_r, cpre_nxt;
  logic [7:0]  dpre_r, dpre_nxt;
  logic [6:0]  seg_r, seg_nxt;
  logic [1:0]  cath_r, cath_nxt;
  logic        status_r, status_nxt;

  logic [7:0]  max_val;
  logic [16:0] cpre_inc;
  logic [8:0]  dpre_inc;
  logic [15:0] dec_prod;
  logic [7:0]  tens;
  logic [7:0]  units;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  always_comb begin
    unique case (radix_r)
      tdmdc_pkg::RADIX_BIN: max_val = 8'd3;
      tdmdc_pkg::RADIX_DEC: max_val = 8'd99;
      default:              max_val = 8'd255;
    endcase
  end

  assign dec_prod = held_r * tdmdc_pkg::DEC_RECIP;

  always_comb begin
    unique case (radix_r)
      tdmdc_pkg::RADIX_BIN: begin
        tens  = {1'b0, held_r[7:1]};
        units = {7'd0, held_r[0]};
      end
      tdmdc_pkg::RADIX_DEC: begin
        tens  = {3'd0, dec_prod[tdmdc_pkg::DEC_RECIP_SHIFT +: 5]};
        units = held_r - 8'(tens * 8'd10);
      end
      default: begin
        tens  = {4'd0, held_r[7:4]};
        units = {4'd0, held_r[3:0]};
      end
    endcase
  end

  assign cpre_inc = {1'b0, cpre_r} + 17'd1;
  assign dpre_inc = {1'b0, dpre_r} + 9'd1;

  always_comb begin
    radix_nxt        = radix_r;
    count_down_nxt   = count_down_r;
    count_period_nxt = count_period_r;
    digit_period_nxt = digit_period_r;
    out_en_nxt       = out_en_r;
    cnt_en_nxt       = cnt_en_r;
    held_nxt         = held_r;
    lit_units_nxt    = lit_units_r;
    cpre_nxt         = cpre_r;
    dpre_nxt         = dpre_r;
    seg_nxt          = seg_r;
    cath_nxt         = cath_r;
    status_nxt       = status_r;
    out_word_nxt     = out_word_r;
    out_valid_nxt    = out_valid_r && out_stall;

    if (cfg_wr) begin
      unique case (cfg_index)
        tdmdc_pkg::CFG_RADIX_MODE:      radix_nxt        = cfg_data[1:0];
        tdmdc_pkg::CFG_COUNT_DOWN:      count_down_nxt   = cfg_data[0];
        tdmdc_pkg::CFG_COUNT_PERIOD_MS: count_period_nxt = cfg_data;
        tdmdc_pkg::CFG_DIGIT_PERIOD_MS: digit_period_nxt = cfg_data[7:0];
        tdmdc_pkg::CFG_OUTPUT_ENABLE: begin
          out_en_nxt = cfg_data[0];
          if (!cfg_data[0]) begin
            cath_nxt = tdmdc_pkg::CATH_DARK;
            dpre_nxt = 8'd0;
          end
        end
        tdmdc_pkg::CFG_COUNT_ENABLE: begin
          cnt_en_nxt = cfg_data[0];
          if (!cfg_data[0]) cpre_nxt = 16'd0;
        end
        default: ;
      endcase
    end

    if (cmd.do_count) begin
      if (in_word_r.func == tdmdc_pkg::FUNC_LOAD) begin
        status_nxt = (in_word_r.load_value > max_val);
        if (in_word_r.load_value <= max_val) held_nxt = in_word_r.load_value;
      end else begin
        status_nxt = 1'b0;
        if (!cnt_en_r) begin
          cpre_nxt = 16'd0;
        end else if (cpre_inc >= {1'b0, count_period_r}) begin
          cpre_nxt = 16'd0;
          if (!count_down_r) begin
            held_nxt = (held_r >= max_val) ? 8'd0 : held_r + 8'd1;
          end else begin
            held_nxt = (held_r == 8'd0) ? max_val : held_r - 8'd1;
          end
        end else begin
          cpre_nxt = cpre_inc[15:0];
        end
      end
    end

    if (cmd.do_digit) begin
      if (in_word_r.func == tdmdc_pkg::FUNC_TICK) begin
        if (!out_en_r) begin
          dpre_nxt = 8'd0;
          cath_nxt = tdmdc_pkg::CATH_DARK;
        end else if (dpre_inc >= {1'b0, digit_period_r}) begin
          dpre_nxt      = 8'd0;
          lit_units_nxt = !lit_units_r;
          if (lit_units_r) begin
            if (tens == 8'd0) begin
              cath_nxt = tdmdc_pkg::CATH_DARK;
            end else begin
              seg_nxt  = tdmdc_pkg::glyph(tens);
              cath_nxt = tdmdc_pkg::CATH_TENS;
            end
          end else begin
            seg_nxt  = tdmdc_pkg::glyph(units);
            cath_nxt = tdmdc_pkg::CATH_UNITS;
          end
        end else begin
          dpre_nxt = dpre_inc[7:0];
        end
      end
      out_word_nxt.segments     = seg_nxt;
      out_word_nxt.tens_lit     = cath_nxt[0];
      out_word_nxt.units_lit    = cath_nxt[1];
      out_word_nxt.shown_number = held_nxt;
      out_word_nxt.status       = status_nxt;
      out_valid_nxt             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_word_r <= in_word;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      radix_r        <= tdmdc_pkg::RADIX_DEC;
      count_down_r   <= 1'b0;
      count_period_r <= 16'd1000;
      digit_period_r <= 8'd1;
      out_en_r       <= 1'b0;
      cnt_en_r       <= 1'b0;
      held_r         <= 8'd0;
      lit_units_r    <= 1'b0;
      cpre_r         <= 16'd0;
      dpre_r         <= 8'd0;
      seg_r          <= 7'd0;
      cath_r         <= tdmdc_pkg::CATH_DARK;
      status_r       <= 1'b0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      radix_r        <= radix_nxt;
      count_down_r   <= count_down_nxt;
      count_period_r <= count_period_nxt;
      digit_period_r <= digit_period_nxt;
      out_en_r       <= out_en_nxt;
      cnt_en_r       <= cnt_en_nxt;
      held_r         <= held_nxt;
      lit_units_r    <= lit_units_nxt;
      cpre_r         <= cpre_nxt;
      dpre_r         <= dpre_nxt;
      seg_r          <= seg_nxt;
      cath_r         <= cath_nxt;
      status_r       <= status_nxt;
    end
  end

endmodule

// File: src/two_digit_mux_display_counter.sv
`timescale 1ns / 1ps

// Two-digit multiplexed seven-segment counter. Each input word is either a
// millisecond tick or a load; every word yields exactly one output word with
// the segment latch, the two cathode enables, the held number and the load
// status. The input is taken in an idle cycle and its result word passes
// through a count stage (load check or prescaler and count step) and then a
// digit stage (radix split, glyph lookup, multiplex step) that writes the
// output register. The digit stage waits while the output register still
// holds an untaken word, and the input is stalled from acceptance until the
// digit stage completes, so a new word is taken only after the last one has
// left the digit stage.
// Configuration words are taken at any time with cfg_ready high and must be
// written only while the block is idle.

module two_digit_mux_display_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tdmdc_pkg::in_word_t              in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tdmdc_pkg::out_word_t             out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tdmdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data
);

  tdmdc_pkg::dp_cmd_t cmd;
  tdmdc_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tdmdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdmdc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
